### sv/rgb_pixel_point_adjust_assert.svh
// Assertion macros for the pixel point adjust block.
// Included by the top level; needs nothing else.
`ifndef RGB_PIXEL_POINT_ADJUST_ASSERT_SVH
`define RGB_PIXEL_POINT_ADJUST_ASSERT_SVH

`ifndef SYNTHESIS
`define RPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### sv/rpa_pkg.sv
// Shared constants, codes and stage types for the pixel point adjust block.
// No dependencies.
package rpa_pkg;

   localparam int CH_W       = 8;
   localparam int CH_COUNT   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // channel slots in the per-channel vectors
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   localparam logic [9:0]      PCT_BASE   = 10'd100;
   localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
   // floor(x/3) == (x*683)>>11 for x below 2048
   localparam logic [9:0]      GRAY_RECIP = 10'd683;
   localparam int              GRAY_SHIFT = 11;
   // (x*5242)>>19 undershoots floor(x/100) by at most one for 17-bit x
   localparam logic [12:0]     PCT_RECIP  = 13'd5242;
   localparam int              PCT_SHIFT  = 19;

   localparam logic [2:0] OP_RED      = 3'd0;
   localparam logic [2:0] OP_GREEN    = 3'd1;
   localparam logic [2:0] OP_BLUE     = 3'd2;
   localparam logic [2:0] OP_RAISE    = 3'd3;
   localparam logic [2:0] OP_REDUCE   = 3'd4;
   localparam logic [2:0] OP_NEGATIVE = 3'd5;
   localparam logic [2:0] OP_GRAY     = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_OPERATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERCENT   = 2'd1;

   typedef struct packed {
      logic [2:0]      operation;
      logic [CH_W-1:0] percent;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic                         gray;
      logic [CH_COUNT-1:0][9:0]     opnd;
      logic [CH_COUNT-1:0][9:0]     fac;
   } prep_type;

   typedef struct packed {
      logic                         gray;
      logic [CH_COUNT-1:0][19:0]    prod;
   } prod_type;

   typedef struct packed {
      logic                         gray;
      logic [CH_COUNT-1:0][16:0]    low;
      logic [CH_COUNT-1:0][9:0]     quot;
   } est_type;

endpackage

### sv/rpa_if.sv
// Channel interfaces: pixel request, pixel response and register write.
// Depends on rpa_pkg.
interface rpa_req_if;
   import rpa_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] blue_in;
   logic [CH_W-1:0] green_in;
   logic [CH_W-1:0] red_in;
   modport source (output valid, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface rpa_rsp_if;
   import rpa_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] blue_out;
   logic [CH_W-1:0] green_out;
   logic [CH_W-1:0] red_out;
   modport source (output valid, blue_out, green_out, red_out, input ready);
   modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

interface rpa_csr_if;
   import rpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/rpa_prep.sv
// Stage 1: decodes the operation into a per-channel operand and factor.
// Depends on rpa_pkg.
module rpa_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rpa_pkg::pixel_type  in_pix,
   input  rpa_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output rpa_pkg::prep_type   out_data
);
   import rpa_pkg::*;

   logic                         valid_ff;
   prep_type                     data_ff;
   prep_type                     data_in;
   logic [CH_COUNT-1:0][CH_W-1:0] chan;
   logic [9:0]                   sum;
   logic [9:0]                   up;
   logic [9:0]                   dn;

   assign chan = {in_pix.red, in_pix.green, in_pix.blue};
   assign sum  = 10'(in_pix.blue) + 10'(in_pix.green) + 10'(in_pix.red);
   assign up   = PCT_BASE + 10'(cfg.percent);
   // reduce by 100 percent or more clamps to black
   assign dn   = (10'(cfg.percent) >= PCT_BASE) ? 10'd0 : PCT_BASE - 10'(cfg.percent);

   always_comb begin
      data_in.gray = 1'b0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         data_in.opnd[ch] = 10'(chan[ch]);
         data_in.fac[ch]  = PCT_BASE;
      end
      unique case (cfg.operation)
         OP_RED:   data_in.fac[CH_RED]   = up;
         OP_GREEN: data_in.fac[CH_GREEN] = up;
         OP_BLUE:  data_in.fac[CH_BLUE]  = up;
         OP_RAISE: begin
            for (int ch = 0; ch < CH_COUNT; ch++) data_in.fac[ch] = up;
         end
         OP_REDUCE: begin
            for (int ch = 0; ch < CH_COUNT; ch++) data_in.fac[ch] = dn;
         end
         OP_NEGATIVE: begin
            for (int ch = 0; ch < CH_COUNT; ch++) data_in.opnd[ch] = 10'(CH_MAX - chan[ch]);
         end
         OP_GRAY: begin
            data_in.gray = 1'b1;
            for (int ch = 0; ch < CH_COUNT; ch++) begin
               data_in.opnd[ch] = sum;
               data_in.fac[ch]  = GRAY_RECIP;
            end
         end
         default: ;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### sv/rpa_mul.sv
// Stage 2: one 10x10 multiply per channel, operand times factor.
// Depends on rpa_pkg.
module rpa_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rpa_pkg::prep_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rpa_pkg::prod_type  out_data
);
   import rpa_pkg::*;

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;

   always_comb begin
      data_in.gray = in_data.gray;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         data_in.prod[ch] = 20'(in_data.opnd[ch]) * 20'(in_data.fac[ch]);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### sv/rpa_div.sv
// Stages 3 and 4: constant divide by reciprocal multiply, then a one-step
// remainder correction and saturation into the output register. Depends on rpa_pkg.
module rpa_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rpa_pkg::prod_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rpa_pkg::pixel_type out_pix
);
   import rpa_pkg::*;

   logic                          est_valid_ff;
   est_type                       est_ff;
   est_type                       est_in;
   logic                          est_ready;
   logic [CH_COUNT-1:0][29:0]     scaled;

   logic                          pix_valid_ff;
   pixel_type                     pix_ff;
   pixel_type                     pix_in;
   logic [CH_COUNT-1:0][17:0]     rem;
   logic [CH_COUNT-1:0][9:0]      quot;
   logic [CH_COUNT-1:0][CH_W-1:0] sat;

   // estimate
   always_comb begin
      est_in.gray = in_data.gray;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         scaled[ch]      = 30'(in_data.prod[ch][16:0]) * 30'(PCT_RECIP);
         est_in.low[ch]  = in_data.prod[ch][16:0];
         est_in.quot[ch] = in_data.gray ? 10'(in_data.prod[ch] >> GRAY_SHIFT)
                                        : 10'(scaled[ch] >> PCT_SHIFT);
      end
   end

   assign in_ready = !est_valid_ff || est_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
      end else if (in_ready) begin
         est_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         est_ff <= est_in;
      end
   end

   // correct: estimate may be one low for the percent path
   always_comb begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         rem[ch]  = 18'(est_ff.low[ch]) - 18'(est_ff.quot[ch]) * 18'(PCT_BASE);
         quot[ch] = (!est_ff.gray && rem[ch] >= 18'(PCT_BASE)) ? est_ff.quot[ch] + 10'd1
                                                                : est_ff.quot[ch];
         sat[ch]  = (quot[ch] > 10'(CH_MAX)) ? CH_MAX : quot[ch][CH_W-1:0];
      end
      pix_in.blue  = sat[CH_BLUE];
      pix_in.green = sat[CH_GREEN];
      pix_in.red   = sat[CH_RED];
   end

   assign est_ready = !pix_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (est_ready) begin
         pix_valid_ff <= est_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (est_ready && est_valid_ff) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = pix_valid_ff;
   assign out_pix   = pix_ff;
endmodule

### sv/rgb_pixel_point_adjust.sv
// Pixel point adjust: per-pixel tone, contrast, negative and grayscale.
// Uses rpa_pkg, the channel interfaces, rpa_prep, rpa_mul and rpa_div.
//
// Usage:
//   req_if carries one BGR pixel per word; rsp_if returns one adjusted
//   pixel per accepted word, in order. csr_if writes the operation
//   register (index 0, low 3 bits) and the percent register (index 1);
//   write them only while no pixel is in flight. csr_if is always ready.
// Path: a word accepted on req_if passes through four register stages
//   (decode, multiply, reciprocal multiply, correct/saturate) before it
//   shows on rsp_if.
// Throughput: one pixel per cycle unless stalled; set by the four-stage
//   valid/ready pipeline, one multiplier per channel in each multiply stage.
// Reset: both registers clear to 0 (red tone, 0 percent, i.e. pass-through)
//   and all stage valid bits clear; no clearing pass is needed.
// Stall: when rsp_if.ready is low, the output word holds; earlier stages
//   keep filling their empty slots, so req_if.ready drops only once all
//   four stages hold a word.
`include "rgb_pixel_point_adjust_assert.svh"

module rgb_pixel_point_adjust (
   input logic   clock,
   input logic   reset,
   rpa_req_if.sink   req_if,
   rpa_rsp_if.source rsp_if,
   rpa_csr_if.sink   csr_if
);
   import rpa_pkg::*;

   cfg_type   cfg_ff;
   pixel_type req_pix;
   pixel_type rsp_pix;
   logic      prep_valid;
   logic      prep_ready;
   prep_type  prep_data;
   logic      mul_valid;
   logic      mul_ready;
   prod_type  mul_data;
   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;
   logic       req_fire;
   logic       rsp_fire;

   // register port
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_OPERATION: cfg_ff.operation <= csr_if.data[2:0];
            REG_PERCENT:   cfg_ff.percent   <= csr_if.data[CH_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_pix.blue  = req_if.blue_in;
   assign req_pix.green = req_if.green_in;
   assign req_pix.red   = req_if.red_in;

   rpa_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_pix    (req_pix),
      .cfg       (cfg_ff),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   rpa_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   rpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_pix   (rsp_pix)
   );

   assign rsp_if.blue_out  = rsp_pix.blue;
   assign rsp_if.green_out = rsp_pix.green;
   assign rsp_if.red_out   = rsp_pix.red;

   // words in flight, for checking
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   always_comb begin
      inflight_in = inflight_ff;
      priority if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `RPA_ASSERT_IMPLY(a_inflight_bound, clock, reset, 1'b1, inflight_ff <= 3'd4, "more than four words in flight")
   `RPA_ASSERT_IMPLY(a_rsp_has_word, clock, reset, rsp_if.valid, inflight_ff != 3'd0, "response without request")
   `RPA_ASSERT_IMPLY(a_stall_from_sink, clock, reset, !req_if.ready, rsp_if.valid && !rsp_if.ready, "input stalled without output back pressure")
   `RPA_ASSERT_NEXT(a_idle_stays_empty, clock, reset, inflight_ff == 3'd0 && !req_fire, !rsp_if.valid, "word appeared from an empty pipeline")

endmodule
